// ===== hw/rtl/lzf_pkg.sv =====
// Shared types and constants for the LZF block decompressor.
`timescale 1ns / 1ps

package lzf_pkg;

  localparam int WindowBytes = 8192;
  localparam int HistAw      = $clog2(WindowBytes);
  localparam int MaxBlock    = 65536;
  localparam int CntW        = 17;
  localparam int QDepth      = 2;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_LIMIT = 2'd1;
  localparam logic [1:0] ST_DIST  = 2'd2;
  localparam logic [1:0] ST_TRUNC = 2'd3;

  typedef enum logic [1:0] {
    PH_CTRL = 2'd0,
    PH_LIT  = 2'd1,
    PH_EXT  = 2'd2,
    PH_DIST = 2'd3
  } phase_t;

  // Back end command kinds
  typedef enum logic [1:0] {
    CMD_LIT  = 2'd0,
    CMD_COPY = 2'd1,
    CMD_FAIL = 2'd2
  } cmd_kind_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_RD   = 2'd1,
    BK_EMIT = 2'd2
  } back_state_t;

  typedef struct packed {
    logic [7:0]     data_byte;
    logic           first_byte;
    logic           last_byte;
    logic [CntW-1:0] out_limit;
  } in_item_t;

  typedef struct packed {
    logic [63:0]     out_bytes;
    logic [3:0]      byte_count;
    logic            run_last;
    logic            block_end;
    logic [1:0]      status;
    logic [CntW-1:0] total_length;
  } out_item_t;

  // Command from the parser to the executor
  typedef struct packed {
    cmd_kind_t       kind;
    logic [7:0]      lit;
    logic [8:0]      len_m2;   // copy length minus 2
    logic [12:0]     dist_m1;  // distance minus 1
    logic            fin;      // sets block_end on the last result
    logic [1:0]      status;
    logic [CntW-1:0] base;     // output count before this command
  } cmd_t;

endpackage

// ===== hw/rtl/lzf_front.sv =====
// Token parser: tracks the block position and issues commands.
`timescale 1ns / 1ps

module lzf_front import lzf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  output logic     cmd_valid,
  input  logic     cmd_full,
  output cmd_t     cmd
);

  phase_t          phase_r, phase_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [CntW-1:0] lim_r, lim_nxt;
  logic [5:0]      lit_left_r, lit_left_nxt;
  logic [8:0]      rlen_r, rlen_nxt;
  logic [4:0]      dhi_r, dhi_nxt;
  logic            done_r, done_nxt;

  logic            acc;
  logic [7:0]      d;
  phase_t          ph;
  logic [CntW-1:0] cnt0, lim0;
  logic [5:0]      left0;
  logic [8:0]      rlen0;
  logic [4:0]      dhi0;
  logic            done0;
  logic [CntW:0]   sum;
  logic [13:0]     ref_dist;
  logic [5:0]      left_dec;

  assign in_stall = cmd_full;
  assign acc      = in_valid && !cmd_full;
  assign d        = in_data.data_byte;
  assign ref_dist = {1'b0, dhi0, d} + 14'd1;
  assign left_dec = (left0 != 6'd0) ? left0 - 6'd1 : 6'd0;

  always_comb begin
    // first_byte view of the state
    if (in_data.first_byte) begin
      cnt0  = '0;
      lim0  = (in_data.out_limit > CntW'(MaxBlock)) ? CntW'(MaxBlock) : in_data.out_limit;
      ph    = PH_CTRL;
      left0 = '0;
      rlen0 = '0;
      dhi0  = '0;
      done0 = 1'b0;
    end else begin
      cnt0  = cnt_r;
      lim0  = lim_r;
      ph    = phase_r;
      left0 = lit_left_r;
      rlen0 = rlen_r;
      dhi0  = dhi_r;
      done0 = done_r;
    end
    phase_nxt    = phase_r;
    cnt_nxt      = cnt_r;
    lim_nxt      = lim_r;
    lit_left_nxt = lit_left_r;
    rlen_nxt     = rlen_r;
    dhi_nxt      = dhi_r;
    done_nxt     = done_r;
    cmd_valid    = 1'b0;
    cmd          = '0;
    cmd.base     = cnt0;
    cmd.lit      = d;
    cmd.len_m2   = rlen0;
    cmd.dist_m1  = {dhi0, d};
    sum          = '0;
    if (acc) begin
      phase_nxt    = ph;
      cnt_nxt      = cnt0;
      lim_nxt      = lim0;
      lit_left_nxt = left0;
      rlen_nxt     = rlen0;
      dhi_nxt      = dhi0;
      done_nxt     = done0;
      if (!done0) begin
        unique case (ph)
          PH_LIT: begin
            cmd_valid    = 1'b1;
            cmd.kind     = CMD_LIT;
            cnt_nxt      = cnt0 + CntW'(1);
            lit_left_nxt = left_dec;
            if (left_dec == 6'd0) begin
              phase_nxt = PH_CTRL;
              cmd.fin   = (cnt0 + CntW'(1) >= lim0) || in_data.last_byte;
            end else if (in_data.last_byte) begin
              cmd.fin    = 1'b1;
              cmd.status = ST_TRUNC;
              phase_nxt  = PH_CTRL;
            end
            done_nxt = cmd.fin;
          end
          PH_EXT: begin
            rlen_nxt  = rlen0 + 9'(d);
            phase_nxt = PH_DIST;
            if (in_data.last_byte) begin
              cmd_valid  = 1'b1;
              cmd.kind   = CMD_FAIL;
              cmd.status = ST_TRUNC;
              done_nxt   = 1'b1;
              phase_nxt  = PH_CTRL;
            end
          end
          PH_DIST: begin
            cmd_valid = 1'b1;
            phase_nxt = PH_CTRL;
            sum       = {1'b0, cnt0} + (CntW+1)'(rlen0) + (CntW+1)'(2);
            if (sum > {1'b0, lim0}) begin
              cmd.kind   = CMD_FAIL;
              cmd.status = ST_LIMIT;
              done_nxt   = 1'b1;
            end else if (CntW'(ref_dist) > cnt0) begin
              cmd.kind   = CMD_FAIL;
              cmd.status = ST_DIST;
              done_nxt   = 1'b1;
            end else begin
              cmd.kind = CMD_COPY;
              cmd.fin  = (sum >= {1'b0, lim0}) || in_data.last_byte;
              done_nxt = cmd.fin;
              cnt_nxt  = sum[CntW-1:0];
            end
          end
          default: begin
            // control byte
            if (d < 8'd32) begin
              sum = {1'b0, cnt0} + (CntW+1)'(d) + (CntW+1)'(1);
              if (sum > {1'b0, lim0}) begin
                cmd_valid  = 1'b1;
                cmd.kind   = CMD_FAIL;
                cmd.status = ST_LIMIT;
                done_nxt   = 1'b1;
              end else begin
                lit_left_nxt = 6'(d) + 6'd1;
                phase_nxt    = PH_LIT;
              end
            end else begin
              rlen_nxt  = 9'(d[7:5]);
              dhi_nxt   = d[4:0];
              phase_nxt = (d[7:5] == 3'd7) ? PH_EXT : PH_DIST;
            end
            if (in_data.last_byte && !(cmd_valid)) begin
              cmd_valid  = 1'b1;
              cmd.kind   = CMD_FAIL;
              cmd.status = ST_TRUNC;
              done_nxt   = 1'b1;
              phase_nxt  = PH_CTRL;
            end else if (cmd_valid) begin
              phase_nxt = PH_CTRL;
            end
          end
        endcase
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_CTRL;
      cnt_r      <= '0;
      lim_r      <= '0;
      lit_left_r <= '0;
      rlen_r     <= '0;
      dhi_r      <= '0;
      done_r     <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      cnt_r      <= cnt_nxt;
      lim_r      <= lim_nxt;
      lit_left_r <= lit_left_nxt;
      rlen_r     <= rlen_nxt;
      dhi_r      <= dhi_nxt;
      done_r     <= done_nxt;
    end
  end

endmodule

// ===== hw/rtl/lzf_cmd_queue.sv =====
// Short command queue between parser and executor.
`timescale 1ns / 1ps

module lzf_cmd_queue import lzf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  cmd_t wr_data,
  output logic full,
  output logic rd_valid,
  input  logic rd_en,
  output cmd_t rd_data
);

  localparam int Aw = $clog2(QDepth);

  cmd_t          mem_r [QDepth];
  logic [Aw-1:0] wp_r, rp_r;
  logic [Aw:0]   cnt_r;

  assign full     = (cnt_r == (Aw+1)'(QDepth));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rp_r];

  // Storage
  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

  // Pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + Aw'(1);
      if (rd_en) rp_r <= rp_r + Aw'(1);
      cnt_r <= cnt_r + (Aw+1)'(wr_en) - (Aw+1)'(rd_en);
    end
  end

endmodule

// ===== hw/rtl/lzf_back.sv =====
// Executor: writes history, runs back-reference copies and packs results.
`timescale 1ns / 1ps

module lzf_back import lzf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmd_valid,
  output logic      cmd_pop,
  input  cmd_t      cmd,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_word
);

  back_state_t st_r, st_nxt;
  logic [7:0]        hist_r [WindowBytes];
  logic [7:0]        rd_q_r;
  logic [HistAw-1:0] src_r, src_nxt;
  logic [8:0]        left_r, left_nxt;   // bytes still to copy minus 1
  logic [CntW-1:0]   pos_r, pos_nxt;
  logic [63:0]       acc_r, acc_nxt;
  logic [3:0]        n_r, n_nxt;
  logic              fin_r, fin_nxt;
  logic              ov_r, ov_nxt;
  out_item_t         od_r, od_nxt;

  logic              wr_en, rd_en;
  logic [HistAw-1:0] wr_a;
  logic [7:0]        wr_d;
  logic              slot;
  logic [63:0]       acc_add;

  assign out_valid = ov_r;
  assign out_word  = od_r;
  assign slot      = !ov_r || !out_stall;
  assign acc_add   = acc_r | (64'(rd_q_r) << {n_r[2:0], 3'b000});

  // History memory
  always_ff @(posedge clk) begin
    if (wr_en) hist_r[wr_a] <= wr_d;
    if (rd_en) rd_q_r <= hist_r[src_r];
  end

  always_comb begin
    st_nxt   = st_r;
    src_nxt  = src_r;
    left_nxt = left_r;
    pos_nxt  = pos_r;
    acc_nxt  = acc_r;
    n_nxt    = n_r;
    fin_nxt  = fin_r;
    ov_nxt   = ov_r && out_stall;
    od_nxt   = od_r;
    cmd_pop  = 1'b0;
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    wr_a     = pos_r[HistAw-1:0];
    wr_d     = rd_q_r;
    unique case (st_r)
      BK_IDLE: begin
        if (cmd_valid && slot) begin
          cmd_pop = 1'b1;
          unique case (cmd.kind)
            CMD_LIT: begin
              wr_en               = 1'b1;
              wr_a                = cmd.base[HistAw-1:0];
              wr_d                = cmd.lit;
              ov_nxt              = 1'b1;
              od_nxt.out_bytes    = 64'(cmd.lit);
              od_nxt.byte_count   = 4'd1;
              od_nxt.run_last     = 1'b1;
              od_nxt.block_end    = cmd.fin;
              od_nxt.status       = cmd.status;
              od_nxt.total_length = (cmd.status == ST_OK) ? cmd.base + CntW'(1) : '0;
            end
            CMD_COPY: begin
              src_nxt  = cmd.base[HistAw-1:0] - cmd.dist_m1 - HistAw'(1);
              left_nxt = cmd.len_m2 + 9'd1;
              pos_nxt  = cmd.base;
              fin_nxt  = cmd.fin;
              acc_nxt  = '0;
              n_nxt    = '0;
              st_nxt   = BK_RD;
            end
            default: begin
              ov_nxt              = 1'b1;
              od_nxt              = '0;
              od_nxt.run_last     = 1'b1;
              od_nxt.block_end    = 1'b1;
              od_nxt.status       = cmd.status;
            end
          endcase
        end
      end
      BK_RD: begin
        // issue read; data arrives next cycle
        rd_en  = 1'b1;
        st_nxt = BK_EMIT;
      end
      BK_EMIT: begin
        // each byte, full pack or not, waits until the output slot frees
        if (slot) begin
          wr_en   = 1'b1;
          pos_nxt = pos_r + CntW'(1);
          src_nxt = src_r + HistAw'(1);
          if (n_r == 4'd7 || left_r == 9'd0) begin
            ov_nxt              = 1'b1;
            od_nxt.out_bytes    = acc_add;
            od_nxt.byte_count   = n_r + 4'd1;
            od_nxt.run_last     = (left_r == 9'd0);
            od_nxt.block_end    = (left_r == 9'd0) && fin_r;
            od_nxt.status       = ST_OK;
            od_nxt.total_length = pos_r + CntW'(1);
            acc_nxt             = '0;
            n_nxt               = '0;
          end else begin
            acc_nxt = acc_add;
            n_nxt   = n_r + 4'd1;
          end
          left_nxt = left_r - 9'd1;
          st_nxt   = (left_r == 9'd0) ? BK_IDLE : BK_RD;
        end
      end
      default: st_nxt = BK_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    src_r  <= src_nxt;
    left_r <= left_nxt;
    pos_r  <= pos_nxt;
    acc_r  <= acc_nxt;
    n_r    <= n_nxt;
    fin_r  <= fin_nxt;
    od_r   <= od_nxt;
  end

endmodule

// ===== hw/rtl/lzf_block_decompressor.sv =====
// LZF block decompressor top level.
// Input channel: one compressed byte per transaction with first_byte,
// last_byte and out_limit. first_byte starts a block and samples the limit.
// Output channel: packed results of up to eight decoded bytes, earliest in the
// lowest byte, with run_last, block_end, status and running total_length.
// A parser classifies bytes and updates position; control and extension
// bytes give no result unless a limit or truncation error ends the block.
// Literal and distance bytes become commands in a two-entry queue read by
// an executor. A literal passes through the queue into the output register;
// the executor takes one literal per cycle while out_stall is low.
// A back reference is copied one byte at a time: a history read in BK_RD
// then a write in BK_EMIT (the single port of the 8 KiB history memory),
// after the command is popped in BK_IDLE; input stalls once the queue fills.
// Reset (rst_n low, synchronous) empties the queue and output register and
// returns the parser to expect a control byte with a zero limit.
// History contents are not cleared; only bytes written in the block are read.
// When out_stall is high the result holds, the executor waits and the queue
// fills, after which in_stall rises.
`timescale 1ns / 1ps

module lzf_block_decompressor import lzf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_word
);

  logic q_wr, q_full, q_valid, q_pop;
  cmd_t q_in, q_out;

  lzf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cmd_valid (q_wr),
    .cmd_full  (q_full),
    .cmd       (q_in)
  );

  lzf_cmd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (q_wr),
    .wr_data  (q_in),
    .full     (q_full),
    .rd_valid (q_valid),
    .rd_en    (q_pop),
    .rd_data  (q_out)
  );

  lzf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_valid),
    .cmd_pop   (q_pop),
    .cmd       (q_out),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule
